[rtl/core/line_rasterizer_macros.svh]
// assertion macros shared by the line rasterizer rtl
// expects clk and rst_n in the scope of each use
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// same-cycle implication
`define LR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/lr_pkg.sv]
// shared types and constants of the line rasterizer
// no dependencies
`default_nettype none
package lr_pkg;

  localparam int COORD_W        = 6;
  localparam int BRUSH_W        = 8;
  localparam int COORD_BITS_DEF = 6;
  localparam int CMDQ_DEPTH     = 2;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [BRUSH_W-1:0] brush;
  } seg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [BRUSH_W-1:0] pixel_brush;
    logic               last_pixel;
  } pixel_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage
`default_nettype wire

[rtl/core/lr_front.sv]
// segment classifier: picks major axis, orders endpoints, forms deltas
// depends on lr_pkg
`default_nettype none
module lr_front #(
  parameter int CB = lr_pkg::COORD_BITS_DEF,
  localparam int CMD_W = 5 * CB + 2 + lr_pkg::BRUSH_W
) (
  input  wire lr_pkg::seg_t  in_seg,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          q_full,
  output logic               q_wr,
  output logic [CMD_W-1:0]   q_data
);
  import lr_pkg::*;

  typedef struct packed {
    logic              steep;
    logic [CB-1:0]     maj0;
    logic [CB-1:0]     maj1;
    logic [CB-1:0]     min0;
    logic              min_dn;
    logic [CB-1:0]     dmaj;
    logic [CB-1:0]     dmin;
    logic [BRUSH_W-1:0] brush;
  } cmd_t;

  logic [CB-1:0] ax, ay, bx, by, adx, ady, min1;
  logic          shallow, swap;
  cmd_t          cmd;

  assign ax = in_seg.start_x[CB-1:0];
  assign ay = in_seg.start_y[CB-1:0];
  assign bx = in_seg.end_x[CB-1:0];
  assign by = in_seg.end_y[CB-1:0];

  assign adx = (bx > ax) ? (bx - ax) : (ax - bx);
  assign ady = (by > ay) ? (by - ay) : (ay - by);
  assign shallow = (ady < adx);

  always_comb begin
    cmd.brush = in_seg.brush;
    cmd.steep = !shallow;
    if (shallow) begin
      swap     = (ax > bx);
      cmd.maj0 = swap ? bx : ax;
      cmd.maj1 = swap ? ax : bx;
      cmd.min0 = swap ? by : ay;
      min1     = swap ? ay : by;
      cmd.dmaj = adx;
      cmd.dmin = ady;
    end else begin
      swap     = (ay > by);
      cmd.maj0 = swap ? by : ay;
      cmd.maj1 = swap ? ay : by;
      cmd.min0 = swap ? bx : ax;
      min1     = swap ? ax : bx;
      cmd.dmaj = ady;
      cmd.dmin = adx;
    end
    cmd.min_dn = (min1 < cmd.min0);
  end

  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;
  assign q_data  = cmd;

endmodule
`default_nettype wire

[rtl/core/lr_cmd_fifo.sv]
// small register queue between classifier and stepper
// depends on lr_pkg and line_rasterizer_macros.svh
`default_nettype none
`include "line_rasterizer_macros.svh"
module lr_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lr_pkg::CMDQ_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  import lr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (rd_en) rd_ptr_r <= ptr_inc(rd_ptr_r);
      priority if (wr_en && !rd_en) begin
        count_r <= count_r + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CNT_W'(1);
      end else begin
        count_r <= count_r;
      end
    end
  end

  `LR_ASSERT_NOW(a_no_overflow, wr_en, !full, "command queue written while full")
  `LR_ASSERT_NOW(a_no_underflow, rd_en, !empty, "command queue read while empty")
  `LR_ASSERT_NEXT(a_count_up, (wr_en && !rd_en), (count_r == $past(count_r) + CNT_W'(1)), "queue count did not rise")

endmodule
`default_nettype wire

[rtl/core/lr_back.sv]
// bresenham stepper: one pixel per cycle, unless the output is held full, into a one-entry output register
// depends on lr_pkg and line_rasterizer_macros.svh
`default_nettype none
`include "line_rasterizer_macros.svh"
module lr_back #(
  parameter int CB = lr_pkg::COORD_BITS_DEF,
  localparam int CMD_W = 5 * CB + 2 + lr_pkg::BRUSH_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire logic [CMD_W-1:0] q_data,
  output logic                  q_pop,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output lr_pkg::pixel_t        out_pix
);
  import lr_pkg::*;

  localparam int EW = CB + 3;

  typedef struct packed {
    logic              steep;
    logic [CB-1:0]     maj0;
    logic [CB-1:0]     maj1;
    logic [CB-1:0]     min0;
    logic              min_dn;
    logic [CB-1:0]     dmaj;
    logic [CB-1:0]     dmin;
    logic [BRUSH_W-1:0] brush;
  } cmd_t;

  cmd_t              cmd;
  bk_state_t         state_r, state_nxt;
  logic [CB-1:0]     maj_r, maj_end_r, min_r, dmaj_r, dmin_r;
  logic              steep_r, dn_r;
  logic [BRUSH_W-1:0] brush_r;
  logic signed [EW-1:0] err_r, err_nxt, err_init;
  logic signed [EW-1:0] dmin2, dmaj2;
  logic              out_valid_r;
  pixel_t            out_r;
  logic              adv, emit, last;
  logic [CB-1:0]     min_nxt;

  assign cmd      = q_data;
  assign adv      = !out_valid_r || out_pop;
  assign last     = (maj_r == maj_end_r);
  assign err_init = signed'(EW'({cmd.dmin, 1'b0})) - signed'(EW'(cmd.dmaj));
  assign dmin2    = signed'(EW'({dmin_r, 1'b0}));
  assign dmaj2    = signed'(EW'({dmaj_r, 1'b0}));

  always_comb begin
    if (err_r > 0) begin
      err_nxt = err_r + dmin2 - dmaj2;
      min_nxt = dn_r ? (min_r - CB'(1)) : (min_r + CB'(1));
    end else begin
      err_nxt = err_r + dmin2;
      min_nxt = min_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_RUN;
      BK_RUN:  if (adv && last) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = !q_empty;
      BK_RUN:  emit  = adv;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      maj_r     <= cmd.maj0;
      maj_end_r <= cmd.maj1;
      min_r     <= cmd.min0;
      dmaj_r    <= cmd.dmaj;
      dmin_r    <= cmd.dmin;
      steep_r   <= cmd.steep;
      dn_r      <= cmd.min_dn;
      brush_r   <= cmd.brush;
      err_r     <= err_init;
    end else if (emit && !last) begin
      maj_r <= maj_r + CB'(1);
      min_r <= min_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.pixel_x     <= steep_r ? COORD_W'(min_r) : COORD_W'(maj_r);
      out_r.pixel_y     <= steep_r ? COORD_W'(maj_r) : COORD_W'(min_r);
      out_r.pixel_brush <= brush_r;
      out_r.last_pixel  <= last;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_pix   = out_r;

  `LR_ASSERT_NOW(a_major_in_range, (state_r == BK_RUN), (maj_r <= maj_end_r), "major coordinate ran past end")
  `LR_ASSERT_NOW(a_pop_when_idle, q_pop, ((state_r == BK_IDLE) && !q_empty), "command taken while busy")
  `LR_ASSERT_NEXT(a_last_ends_line, (emit && last), (state_r == BK_IDLE), "stepper did not stop after last pixel")

endmodule
`default_nettype wire

[rtl/core/line_rasterizer.sv]
// line rasterizer: segment in, one pixel transaction per cycle out when not stalled (bresenham)
// first pixel of a segment passes the command queue, stepper registers and output register
// the stepper loop loads one command and then emits one pixel per cycle unless its output
//   register is held full; it takes the next command only after the last pixel
// a 2-entry command queue lets new segments be accepted while a line is being stepped
// reset: synchronous active-low rst_n empties the queue and output register; no clearing pass
`default_nettype none
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
  parameter int CMDQ_DEPTH = lr_pkg::CMDQ_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  // segment transactions
  input  wire lr_pkg::seg_t   in_seg,
  input  wire logic           in_push,
  output logic                in_full,
  // pixel transactions
  output lr_pkg::pixel_t      out_pix,
  output logic                out_empty,
  input  wire logic           out_pop
);
  import lr_pkg::*;

  // width of one classified command: axis flag, three coordinates, direction,
  // two deltas and the brush
  localparam int CMD_W = 5 * COORD_BITS + 2 + BRUSH_W;

  logic             q_wr, q_full, q_rd, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // front: picks the major axis, orders the endpoints so stepping counts up
  lr_front #(
    .CB (COORD_BITS)
  ) u_front (
    .in_seg  (in_seg),
    .in_push (in_push),
    .in_full (in_full),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  // decouples segment intake from pixel stepping
  lr_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // back: error-term stepper feeding the output register
  lr_back #(
    .CB (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_pix   (out_pix)
  );

endmodule
`default_nettype wire
